// ===== design/assert_macros.svh =====
// Shared assertion macros. Clock is clock, reset is reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the next cycle, ignored while in reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Antecedent implies consequent in the same cycle, ignored while in reset.
`define ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle check that also holds across reset.
`define ASSERT_NEXT_RST(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/sup_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sup_pkg;

   localparam int MAX_POINTS = 64;
   localparam int IDX_W      = $clog2(MAX_POINTS);
   localparam int CNT_W      = $clog2(MAX_POINTS + 1);
   localparam int COORD_W    = 32;
   localparam int ENTRY_W    = 2 * COORD_W;

   typedef struct packed {
      logic signed [COORD_W-1:0] in_x;
      logic signed [COORD_W-1:0] in_y;
      logic                      batch_end;
   } req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] out_x;
      logic signed [COORD_W-1:0] out_y;
      logic                      out_last;
      logic                      overflow;
   } rsp_type;

   // one table entry as stored in the RAM
   typedef struct packed {
      logic signed [COORD_W-1:0] key;
      logic signed [COORD_W-1:0] value;
   } entry_type;

   // controller -> datapath
   typedef struct packed {
      logic accept;     // take the request item
      logic ins_read;   // read entry idx-1
      logic ins_shift;  // move read entry up to idx, idx--
      logic ins_place;  // write new point at idx, count++
      logic dd_start;   // clear read/write pointers for the dedup pass
      logic dd_read;    // read entry rd
      logic dd_take;    // prev <= read entry, rd++
      logic dd_emit;    // emit prev, store at wr, then take
      logic dd_final;   // emit prev as last, store at wr, set count
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic full;
      logic in_end;
      logic pend_end;
      logic idx_zero;
      logic new_less;
      logic rd_done;
      logic rd_first;
      logic key_diff;
      logic out_free;
   } sts_type;

endpackage

`default_nettype wire

// ===== design/sup_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sup_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== design/sup_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sup_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output      logic             req_stall,
   input  wire sup_pkg::sts_type sts,
   output      sup_pkg::cmd_type cmd
);
   import sup_pkg::*;

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_INS_RD  = 3'd1;
   localparam logic [2:0] S_INS_CMP = 3'd2;
   localparam logic [2:0] S_DD_RD   = 3'd3;
   localparam logic [2:0] S_DD_CMP  = 3'd4;
   localparam logic [2:0] S_DD_LAST = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (!sts.full) begin
                  state_in = S_INS_RD;
               end else if (sts.in_end) begin
                  cmd.dd_start = 1'b1;
                  state_in     = S_DD_RD;
               end
            end
         end
         S_INS_RD: begin
            if (sts.idx_zero) begin
               cmd.ins_place = 1'b1;
               cmd.dd_start  = sts.pend_end;
               state_in      = sts.pend_end ? S_DD_RD : S_IDLE;
            end else begin
               cmd.ins_read = 1'b1;
               state_in     = S_INS_CMP;
            end
         end
         S_INS_CMP: begin
            if (sts.new_less) begin
               cmd.ins_shift = 1'b1;
               state_in      = S_INS_RD;
            end else begin
               cmd.ins_place = 1'b1;
               cmd.dd_start  = sts.pend_end;
               state_in      = sts.pend_end ? S_DD_RD : S_IDLE;
            end
         end
         S_DD_RD: begin
            if (sts.rd_done) begin
               state_in = S_DD_LAST;
            end else begin
               cmd.dd_read = 1'b1;
               state_in    = S_DD_CMP;
            end
         end
         S_DD_CMP: begin
            if (sts.rd_first || !sts.key_diff) begin
               cmd.dd_take = 1'b1;
               state_in    = S_DD_RD;
            end else if (sts.out_free) begin
               cmd.dd_emit = 1'b1;
               state_in    = S_DD_RD;
            end
         end
         S_DD_LAST: begin
            if (sts.out_free) begin
               cmd.dd_final = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/sup_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sup_dp (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire sup_pkg::req_type req_data,
   input  wire logic             rsp_stall,
   output      logic             rsp_valid,
   output      sup_pkg::rsp_type rsp_data,
   input  wire sup_pkg::cmd_type cmd,
   output      sup_pkg::sts_type sts
);
   import sup_pkg::*;

   entry_type        new_ff, new_in;
   logic             pend_end_ff, pend_end_in;
   entry_type        prev_ff, prev_in;
   rsp_type          rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] rd_ff, rd_in;
   logic [CNT_W-1:0] wr_ff, wr_in;
   logic             dropped_ff, dropped_in;

   logic [CNT_W-1:0]   idx_dec;
   logic               ram_wr_en;
   logic [IDX_W-1:0]   ram_wr_addr;
   entry_type          ram_wr_entry;
   logic               ram_rd_en;
   logic [IDX_W-1:0]   ram_rd_addr;
   logic [ENTRY_W-1:0] ram_rd_data;
   entry_type          rd_entry;
   logic               out_free;

   assign idx_dec  = idx_ff - CNT_W'(1);
   assign rd_entry = entry_type'(ram_rd_data);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // RAM port muxing
   assign ram_wr_en   = cmd.ins_shift | cmd.ins_place | cmd.dd_emit | cmd.dd_final;
   assign ram_wr_addr = (cmd.ins_shift || cmd.ins_place) ? idx_ff[IDX_W-1:0]
                                                         : wr_ff[IDX_W-1:0];
   always_comb begin
      if (cmd.ins_shift) begin
         ram_wr_entry = rd_entry;
      end else if (cmd.ins_place) begin
         ram_wr_entry = new_ff;
      end else begin
         ram_wr_entry = prev_ff;
      end
   end
   assign ram_rd_en   = cmd.ins_read | cmd.dd_read;
   assign ram_rd_addr = cmd.ins_read ? idx_dec[IDX_W-1:0] : rd_ff[IDX_W-1:0];

   sup_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_POINTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_entry),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      new_in       = new_ff;
      pend_end_in  = pend_end_ff;
      prev_in      = prev_ff;
      rsp_in       = rsp_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      rd_in        = rd_ff;
      wr_in        = wr_ff;
      dropped_in   = dropped_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (cmd.accept) begin
         new_in.key  = req_data.in_x;
         new_in.value = req_data.in_y;
         pend_end_in = req_data.batch_end;
         idx_in      = count_ff;
         if (count_ff == CNT_W'(MAX_POINTS)) begin
            dropped_in = 1'b1;
         end
      end
      if (cmd.ins_shift) begin
         idx_in = idx_dec;
      end
      if (cmd.ins_place) begin
         count_in = count_ff + CNT_W'(1);
      end
      if (cmd.dd_start) begin
         rd_in = '0;
         wr_in = '0;
      end
      if (cmd.dd_take || cmd.dd_emit) begin
         prev_in = rd_entry;
         rd_in   = rd_ff + CNT_W'(1);
      end
      if (cmd.dd_emit || cmd.dd_final) begin
         rsp_in.out_x    = prev_ff.key;
         rsp_in.out_y    = prev_ff.value;
         rsp_in.out_last = cmd.dd_final;
         rsp_in.overflow = dropped_ff;
         rsp_valid_in    = 1'b1;
         wr_in           = wr_ff + CNT_W'(1);
      end
      if (cmd.dd_final) begin
         count_in   = wr_ff + CNT_W'(1);
         dropped_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         dropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
         rd_ff        <= '0;
         wr_ff        <= '0;
         pend_end_ff  <= 1'b0;
      end else begin
         count_ff     <= count_in;
         dropped_ff   <= dropped_in;
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
         rd_ff        <= rd_in;
         wr_ff        <= wr_in;
         pend_end_ff  <= pend_end_in;
      end
      new_ff  <= new_in;
      prev_ff <= prev_in;
      rsp_ff  <= rsp_in;
   end

   assign sts.full     = (count_ff == CNT_W'(MAX_POINTS));
   assign sts.in_end   = req_data.batch_end;
   assign sts.pend_end = pend_end_ff;
   assign sts.idx_zero = (idx_ff == '0);
   assign sts.new_less = (new_ff.key < rd_entry.key);
   assign sts.rd_done  = (rd_ff == count_ff);
   assign sts.rd_first = (rd_ff == '0);
   assign sts.key_diff = (rd_entry.key != prev_ff.key);
   assign sts.out_free = out_free;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// ===== design/sorted_unique_point_table.sv =====
// Insertion: a stored point walks the table RAM from the top down, moving up each entry with a
// larger x, and is written into the gap; a point that arrives at a full table is dropped.
// Input: stalled while a walk or pass runs; a new point is taken only after the last is done.
// Batch end adds a dedup/emit pass, which also waits on any output stall.
// Reset: synchronous, active high; clears the count, drop flag, controller and output valid.
// Table RAM contents are not cleared; only entries below the count are ever read.
`timescale 1ns / 1ps
`default_nettype none

// The table is kept sorted by x at all times: each new point is inserted
// after every entry with an equal or smaller x, which matches a stable sort
// of the arrival order. Duplicates stay until batch end, where one pass
// walks the table, keeps the last point of each run of equal x, compacts
// the table in place and emits the survivors.
module sorted_unique_point_table (
   input  wire logic             clock,
   input  wire logic             reset,
   // point items in
   input  wire logic             req_valid,
   output      logic             req_stall,
   input  wire sup_pkg::req_type req_data,
   // sorted table items out
   output      logic             rsp_valid,
   input  wire logic             rsp_stall,
   output      sup_pkg::rsp_type rsp_data
);
   import sup_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // State machine: insertion walk, dedup walk, final emit.
   sup_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Table RAM, counters, held point, previous entry and output register.
   sup_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule

`default_nettype wire

// ===== design/sup_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sup_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_stall,
   input wire logic             rsp_valid,
   input wire logic             rsp_stall,
   input wire sup_pkg::rsp_type rsp_data
);
   import sup_pkg::*;

   logic rsp_take;
   logic req_take;
   logic mid_emit;
   assign rsp_take = rsp_valid && !rsp_stall;
   assign req_take = req_valid && !req_stall;
   assign mid_emit = rsp_valid && !rsp_data.out_last;

   `ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "item changed")
   `ASSERT_NEXT_RST(a_rst_idle, reset, !rsp_valid, "result valid after reset")
   `ASSERT_SAME(a_accept_idle, req_take, !mid_emit, "input taken mid emit")
   `ASSERT_SAME(a_emit_blocks, rsp_take && !rsp_data.out_last, req_stall, "input open mid emit")

endmodule

bind sorted_unique_point_table sup_checker u_sup_checker (.*);

`default_nettype wire

// ===== tb/sorted_unique_point_table_tb.sv =====
`timescale 1ns / 1ps

module sorted_unique_point_table_tb;
   import sup_pkg::*;

   // Run shape. The watchdog limit covers the longest quiet stretch many times over:
   // the forced receiver hold-off, a full 64-entry insertion walk and a full emit pass all
   // stack up well below it.
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int DRAIN_CYCLES   = 2 * MAX_POINTS + 100;
   localparam int HOLD_CYCLES    = 400;
   localparam int HOLD_AFTER     = 150;
   localparam int RANDOM_POINTS  = 215;
   localparam int POOL_SIZE      = 40;

   // One row of stimulus. Rows with a typed result carry the single point the
   // emit must produce. Every other row is checked against the table predictor.
   typedef struct {
      req_type point;
      bit      typed;
      rsp_type result;
   } stim_row_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   int unsigned send_idle_pct = 38;
   int unsigned rcv_idle_pct  = 57;
   int          mismatches    = 0;
   int          points_seen   = 0;
   int          quiet_cycles  = 0;

   stim_row_type point_rows[$];
   rsp_type      expected_points[$];
   rsp_type      emit_buf[$];

   // Predictor state: the point table as the block should hold it.
   logic signed [COORD_W-1:0] tbl_key [MAX_POINTS];
   logic signed [COORD_W-1:0] tbl_val [MAX_POINTS];
   int                        tbl_count   = 0;
   bit                        tbl_dropped = 1'b0;

   sorted_unique_point_table u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Appends one point to the predicted table. On batch end: stable sort by
   // signed x, keep the newest point of each run of equal x, and leave the
   // emitted points in emit_buf. Points beyond a full table are dropped.
   task automatic model_point(input req_type p);
      logic signed [COORD_W-1:0] k;
      logic signed [COORD_W-1:0] v;
      int                        i;
      int                        j;
      int                        wr;
      rsp_type                   r;
      emit_buf.delete();
      if (tbl_count < MAX_POINTS) begin
         tbl_key[tbl_count] = p.in_x;
         tbl_val[tbl_count] = p.in_y;
         tbl_count++;
      end else begin
         tbl_dropped = 1'b1;
      end
      if (!p.batch_end) return;
      // insertion sort; strict less-than keeps equal keys in arrival order
      for (i = 1; i < tbl_count; i++) begin
         k = tbl_key[i];
         v = tbl_val[i];
         j = i;
         while (j > 0 && k < tbl_key[j-1]) begin
            tbl_key[j] = tbl_key[j-1];
            tbl_val[j] = tbl_val[j-1];
            j--;
         end
         tbl_key[j] = k;
         tbl_val[j] = v;
      end
      // the last entry of a run of equal keys is the newest one
      wr = 0;
      for (i = 0; i < tbl_count; i++) begin
         if (i + 1 == tbl_count || tbl_key[i] != tbl_key[i+1]) begin
            tbl_key[wr] = tbl_key[i];
            tbl_val[wr] = tbl_val[i];
            wr++;
         end
      end
      tbl_count = wr;
      for (i = 0; i < tbl_count; i++) begin
         r.out_x    = tbl_key[i];
         r.out_y    = tbl_val[i];
         r.out_last = (i == tbl_count - 1);
         r.overflow = tbl_dropped;
         emit_buf   = {emit_buf, r};
      end
      tbl_dropped = 1'b0;
   endtask

   function automatic void add_row(input logic [COORD_W-1:0] x, y, input logic last_pt,
                                   input bit typed, input logic [COORD_W-1:0] ex, ey);
      stim_row_type r;
      r.point.in_x      = x;
      r.point.in_y      = y;
      r.point.batch_end = last_pt;
      r.typed           = typed;
      r.result.out_x    = ex;
      r.result.out_y    = ey;
      r.result.out_last = 1'b1;
      r.result.overflow = 1'b0;
      point_rows        = {point_rows, r};
   endfunction

   function automatic void check_field(input string name, input logic [COORD_W-1:0] want,
                                       input logic [COORD_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %h, actual %h", $time, name, want, got);
         mismatches++;
      end
   endfunction

   task automatic check_point(input rsp_type got);
      rsp_type want;
      if (expected_points.size() == 0) begin
         $display("%0t: point with none expected: x=%h y=%h last=%b overflow=%b",
                  $time, got.out_x, got.out_y, got.out_last, got.overflow);
         mismatches++;
         return;
      end
      want = expected_points.pop_front();
      check_field("out_x", want.out_x, got.out_x);
      check_field("out_y", want.out_y, got.out_y);
      check_field("out_last", want.out_last, got.out_last);
      check_field("overflow", want.overflow, got.overflow);
   endtask

   // Offers one item after a random idle gap. Valid stays high from one item
   // into the next when no gap is drawn, so it is never lowered and raised in
   // one step. The predictor runs at the accepting edge.
   task automatic send_point(input stim_row_type row);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= row.point;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      model_point(row.point);
      if (row.typed) expected_points = {expected_points, row.result};
      else expected_points = {expected_points, emit_buf};
   endtask

   // Receiver: checks each accepted point and draws the stall for the next
   // cycle. Once, partway through the run, it holds off for a long stretch so
   // that the emit pass backs up and the block stalls its input.
   initial begin : result_side
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            check_point(rsp_data);
            points_seen++;
            if (points_seen == HOLD_AFTER) hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) hold_left--;
         rsp_stall <= (hold_left > 0) || ($urandom_range(99) < rcv_idle_pct);
      end
   end

   // Watchdog: counts cycles in which neither channel moves an item.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("sorted_unique_point_table verification failed");
         $finish;
      end
   end

   initial begin : stimulus
      stim_row_type              row;
      logic signed [COORD_W-1:0] key_pool [POOL_SIZE];
      int                        batch_len;
      int                        sent;
      int                        i;

      // Directed points. The table carries over between batches, so only the
      // first emits after reset can be read off directly.
      // first point after reset: extreme key, extreme value
      add_row(32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000);
      // same key again: the newer point replaces the older
      add_row(32'h7FFF_FFFF, 32'h0000_0000, 1'b1, 1'b1, 32'h7FFF_FFFF, 32'h0000_0000);
      // signed ordering around zero, both extremes, duplicates inside a batch
      add_row(32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0, '0, '0);
      add_row(32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 1'b0, '0, '0);
      add_row(32'hFFFF_FFFF, 32'h0000_0001, 1'b0, 1'b0, '0, '0);
      add_row(32'h0000_0001, 32'hAAAA_AAAA, 1'b0, 1'b0, '0, '0);
      add_row(32'h8000_0000, 32'h5555_5555, 1'b0, 1'b0, '0, '0);
      add_row(32'h0000_0000, 32'h1234_5678, 1'b0, 1'b0, '0, '0);
      add_row(32'hFFFF_0000, 32'h0001_0000, 1'b1, 1'b0, '0, '0);
      // batch of one duplicate: table size unchanged, one value updated
      add_row(32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, '0, '0);
      add_row(32'h7FFF_FFFE, 32'hDEAD_BEEF, 1'b0, 1'b0, '0, '0);
      add_row(32'h8000_0001, 32'h0F0F_0F0F, 1'b0, 1'b0, '0, '0);
      add_row(32'h0001_0000, 32'hF0F0_F0F0, 1'b0, 1'b0, '0, '0);
      add_row(32'h8000_0001, 32'hCAFE_F00D, 1'b0, 1'b0, '0, '0);
      add_row(32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, '0, '0);

      // Random keys come mostly from a small pool so that batches carry
      // duplicates and the table stays below full between batches; long
      // batches then overrun it and exercise the drop path.
      foreach (key_pool[k]) key_pool[k] = $urandom;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (point_rows[r]) send_point(point_rows[r]);

      sent = 0;
      while (sent < RANDOM_POINTS) begin
         batch_len = ($urandom_range(4) == 0) ? $urandom_range(25, 45) : $urandom_range(1, 16);
         // the final batch is cut short so that the run ends on a batch end
         if (batch_len > RANDOM_POINTS - sent) batch_len = RANDOM_POINTS - sent;
         for (i = 0; i < batch_len; i++) begin
            // idle pattern: receiver-heavy, then sender-heavy, then none
            if (sent >= 2 * RANDOM_POINTS / 3) begin
               send_idle_pct = 0;
               rcv_idle_pct  = 0;
            end else if (sent >= RANDOM_POINTS / 3) begin
               send_idle_pct = 57;
               rcv_idle_pct  = 38;
            end
            row.typed             = 1'b0;
            row.result            = '0;
            // rare fresh keys add noise without filling the table for good
            row.point.in_x        = ($urandom_range(39) == 0) ? $urandom
                                    : key_pool[$urandom_range(POOL_SIZE - 1)];
            row.point.in_y        = $urandom;
            row.point.batch_end   = (i == batch_len - 1);
            send_point(row);
            sent++;
         end
      end
      req_valid <= 1'b0;

      while (expected_points.size() != 0) @(posedge clock);
      // stray points after the last expected one would show up here
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("sorted_unique_point_table verification clean");
      end else begin
         $display("sorted_unique_point_table verification failed");
      end
      $finish;
   end

endmodule
